/* rtl/hpsm_pkg.sv */
// hpsm_pkg: widths, reset values, status codes and register indexes
// shared by the hall period speed meter RTL. No dependencies.
`default_nettype none

package hpsm_pkg;

   // period ring
   localparam int PERIOD_SLOTS = 8;   // power of two: the mean is a shift
   localparam int SLOT_W       = $clog2(PERIOD_SLOTS);
   localparam int PERIOD_W     = 32;
   localparam int SUM_W        = PERIOD_W + SLOT_W;
   localparam int STALE_W      = SLOT_W + 1;

   // configuration
   localparam int FREQ_W       = 32;
   localparam int PP_W         = 7;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMER_FREQUENCY = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PP_COUNT        = 1'd1;
   localparam logic [FREQ_W-1:0]      FREQ_RESET          = 32'd72000000;
   localparam logic [PP_W-1:0]        PP_RESET            = 7'd1;

   // datapath widths
   localparam int MUL_W        = 32;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int AVGPP_W      = PERIOD_W + PP_W;   // mean * pole pairs
   localparam int DEN_W        = AVGPP_W + 3;       // times six
   localparam int SPEED_W      = 48;
   localparam int OMEGA_W      = 51;
   localparam int FRAC_SHIFT   = 16;
   localparam int HALF_W       = SPEED_W / 2;
   localparam int CNT_W        = $clog2(SPEED_W);
   localparam int STATUS_W     = 2;

   // fractional part of 2*pi in Q.32 (integer part 6 is a shift-add)
   localparam logic [MUL_W-1:0] TWO_PI_FRAC = 32'd1216271633;

   localparam logic [PERIOD_W-1:0] PERIOD_ONES = {PERIOD_W{1'b1}};
   localparam logic [SUM_W-1:0]    SUM_RESET   =
      SUM_W'(PERIOD_SLOTS) * SUM_W'(PERIOD_ONES);
   localparam logic [SPEED_W-1:0]  SPEED_MAX   = {SPEED_W{1'b1}};
   localparam logic [OMEGA_W-1:0]  OMEGA_MAX   = {OMEGA_W{1'b1}};

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_VALID     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_STALLED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

endpackage

`default_nettype wire

/* rtl/hall_period_speed_meter_top.sv */
// hall_period_speed_meter_top: hall-edge period averaging tachometer.
// Depends on hpsm_pkg (widths, constants, status codes).
// Iterative: one shared 32x32 multiplier and a restoring divider.
//
// Usage:
//  - Request channel (req_*): each request is a hall-edge capture
//    (event_kind 0, capture_value = ticks since last edge) or a timer
//    overflow (event_kind 1, all ring slots go stale). The ring, sum and
//    stale count update at the edge the request is accepted.
//  - Response channel (rsp_*): exactly one response per request with
//    status, speed_rps (Q.16 rev/s) and omega (Q.16 rad/s).
//  - csr_*: plain write port, index 0 timer frequency, 1 pole pairs.
//    Write only while idle.
// Path from accept to rsp_valid: on the normal path check, den multiply,
//  scale, 48 divider steps, two 2*pi partial products, finish; when
//  slots are stale or the mean is zero, check goes straight to finish.
//  The 48-step restoring divider is the longest part of the normal path.
// One request at a time: the next is taken only once the sequencer is idle;
//  req_stall is high while a request is in the sequencer.
//  A finished response waits in the output register, so the next request
//  is taken while the previous response is stalled; the sequencer holds
//  in its finish step only if the output register is still occupied.
// Reset (synchronous): ring all ones, all slots stale, write slot 0,
//  timer frequency 72 MHz, pole pairs 1, no response pending.
`default_nettype none

module hall_period_speed_meter_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_event_kind,
   input  wire logic [hpsm_pkg::PERIOD_W-1:0]      req_capture_value,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [hpsm_pkg::STATUS_W-1:0]           rsp_status,
   output logic [hpsm_pkg::SPEED_W-1:0]            rsp_speed_rps,
   output logic [hpsm_pkg::OMEGA_W-1:0]            rsp_omega,
   // configuration
   input  wire logic                               csr_write_enable,
   input  wire logic [hpsm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hpsm_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;  // pick status / start math
   localparam logic [2:0] S_MUL   = 3'd2;  // mean * pole pairs
   localparam logic [2:0] S_DEN   = 3'd3;  // times six, load divider
   localparam logic [2:0] S_DIV   = 3'd4;  // one quotient bit per cycle
   localparam logic [2:0] S_MULA  = 3'd5;  // high half of speed * frac(2pi)
   localparam logic [2:0] S_MULB  = 3'd6;  // low half
   localparam logic [2:0] S_FIN   = 3'd7;  // combine, load output

   localparam int R_W = hpsm_pkg::PROD_W - 8 + 2;   // frac/omega sum width

   // ---------------------------------------------------------------
   // state
   // ---------------------------------------------------------------
   logic [2:0]                          state_ff, state_in;
   logic [hpsm_pkg::PERIOD_W-1:0]       ring_ff [hpsm_pkg::PERIOD_SLOTS];
   logic [hpsm_pkg::PERIOD_SLOTS-1:0]   stale_ff;
   logic [hpsm_pkg::STALE_W-1:0]        stale_cnt_ff;
   logic [hpsm_pkg::SLOT_W-1:0]         slot_ff;
   logic [hpsm_pkg::SUM_W-1:0]          sum_ff;
   logic [hpsm_pkg::FREQ_W-1:0]         freq_ff;
   logic [hpsm_pkg::PP_W-1:0]           pole_ff;

   logic [hpsm_pkg::STATUS_W-1:0]       stat_ff, stat_in;
   logic [hpsm_pkg::PROD_W-1:0]         prod_ff;
   logic [hpsm_pkg::PROD_W-1:0]         phi_ff, phi_in;
   logic [hpsm_pkg::DEN_W-1:0]          den_ff, den_in;
   logic [hpsm_pkg::DEN_W-1:0]          rem_ff, rem_in;
   logic [hpsm_pkg::SPEED_W-1:0]        quo_ff, quo_in;
   logic [hpsm_pkg::CNT_W-1:0]          cnt_ff, cnt_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [hpsm_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [hpsm_pkg::SPEED_W-1:0]        rsp_speed_ff;
   logic [hpsm_pkg::OMEGA_W-1:0]        rsp_omega_ff;

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------
   logic                                accept;
   logic [hpsm_pkg::PERIOD_W-1:0]       old_period;
   logic [hpsm_pkg::PERIOD_W-1:0]       avg;
   logic [hpsm_pkg::PP_W-1:0]           pp_eff;

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign old_period = ring_ff[slot_ff];
   assign avg        = sum_ff[hpsm_pkg::SUM_W-1:hpsm_pkg::SLOT_W];
   assign pp_eff     = (pole_ff == '0) ? hpsm_pkg::PP_W'(1) : pole_ff;

   // ---------------------------------------------------------------
   // shared multiplier
   // ---------------------------------------------------------------
   logic [hpsm_pkg::MUL_W-1:0]          mul_a, mul_b;
   logic [hpsm_pkg::PROD_W-1:0]         mul_p;

   always_comb begin
      case (state_ff)
         S_MULA: begin
            mul_a = hpsm_pkg::MUL_W'(quo_ff[hpsm_pkg::SPEED_W-1:hpsm_pkg::HALF_W]);
            mul_b = hpsm_pkg::TWO_PI_FRAC;
         end
         S_MULB: begin
            mul_a = hpsm_pkg::MUL_W'(quo_ff[hpsm_pkg::HALF_W-1:0]);
            mul_b = hpsm_pkg::TWO_PI_FRAC;
         end
         default: begin
            mul_a = avg;
            mul_b = hpsm_pkg::MUL_W'(pp_eff);
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // ---------------------------------------------------------------
   // divider step: restoring, one quotient bit a cycle
   // ---------------------------------------------------------------
   logic [hpsm_pkg::DEN_W:0]            trial, diff;
   logic                                ge;

   assign trial = {rem_ff, quo_ff[hpsm_pkg::SPEED_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = !diff[hpsm_pkg::DEN_W];

   // ---------------------------------------------------------------
   // finish: omega = floor(s*6 + s*frac/2^32), frac split at bit 24
   // ---------------------------------------------------------------
   logic [R_W-1:0]                      lo_sum, frac, s_x6, omega_raw;
   logic [hpsm_pkg::OMEGA_W-1:0]        omega_sat;
   logic                                load_out;

   always_comb begin
      lo_sum    = R_W'({phi_ff[7:0], 24'd0}) + R_W'(prod_ff);
      frac      = R_W'(phi_ff[hpsm_pkg::PROD_W-1:8]) + R_W'(lo_sum[R_W-1:32]);
      s_x6      = R_W'({quo_ff, 2'b00}) + R_W'({quo_ff, 1'b0});
      omega_raw = s_x6 + frac;
      omega_sat = (omega_raw[R_W-1:hpsm_pkg::OMEGA_W] != '0) ?
                  hpsm_pkg::OMEGA_MAX : omega_raw[hpsm_pkg::OMEGA_W-1:0];
   end

   assign load_out = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      stat_in  = stat_ff;
      phi_in   = phi_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stale_cnt_ff != '0) begin
               stat_in  = hpsm_pkg::STATUS_STALLED;
               state_in = S_FIN;
            end else if (avg == '0) begin
               stat_in  = hpsm_pkg::STATUS_SATURATED;
               state_in = S_FIN;
            end else begin
               stat_in  = hpsm_pkg::STATUS_VALID;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_DEN;
         end
         S_DEN: begin
            den_in   = {1'b0, prod_ff[hpsm_pkg::AVGPP_W-1:0], 2'b00}
                     + {2'b00, prod_ff[hpsm_pkg::AVGPP_W-1:0], 1'b0};
            rem_in   = '0;
            quo_in   = {freq_ff, {hpsm_pkg::FRAC_SHIFT{1'b0}}};
            cnt_in   = hpsm_pkg::CNT_W'(hpsm_pkg::SPEED_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = ge ? diff[hpsm_pkg::DEN_W-1:0] : trial[hpsm_pkg::DEN_W-1:0];
            quo_in = {quo_ff[hpsm_pkg::SPEED_W-2:0], ge};
            cnt_in = cnt_ff - hpsm_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_MULA;
            end
         end
         S_MULA: begin
            state_in = S_MULB;
         end
         S_MULB: begin
            phi_in   = prod_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   // control state, ring and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
         stale_ff     <= '1;
         stale_cnt_ff <= hpsm_pkg::STALE_W'(hpsm_pkg::PERIOD_SLOTS);
         sum_ff       <= hpsm_pkg::SUM_RESET;
         freq_ff      <= hpsm_pkg::FREQ_RESET;
         pole_ff      <= hpsm_pkg::PP_RESET;
         for (int i = 0; i < hpsm_pkg::PERIOD_SLOTS; i++) begin
            ring_ff[i] <= hpsm_pkg::PERIOD_ONES;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               hpsm_pkg::CSR_TIMER_FREQUENCY: freq_ff <= csr_write_data;
               hpsm_pkg::CSR_PP_COUNT:        pole_ff <= csr_write_data[hpsm_pkg::PP_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            if (!req_event_kind) begin
               // capture: replace the oldest period, keep the sum current
               ring_ff[slot_ff] <= req_capture_value;
               sum_ff <= sum_ff - hpsm_pkg::SUM_W'(old_period)
                                + hpsm_pkg::SUM_W'(req_capture_value);
               if (stale_ff[slot_ff]) begin
                  stale_ff[slot_ff] <= 1'b0;
                  stale_cnt_ff      <= stale_cnt_ff - hpsm_pkg::STALE_W'(1);
               end
               slot_ff <= (slot_ff == hpsm_pkg::SLOT_W'(hpsm_pkg::PERIOD_SLOTS - 1)) ?
                          '0 : slot_ff + hpsm_pkg::SLOT_W'(1);
            end else begin
               // overflow: everything stale, write slot kept
               for (int i = 0; i < hpsm_pkg::PERIOD_SLOTS; i++) begin
                  ring_ff[i] <= hpsm_pkg::PERIOD_ONES;
               end
               stale_ff     <= '1;
               stale_cnt_ff <= hpsm_pkg::STALE_W'(hpsm_pkg::PERIOD_SLOTS);
               sum_ff       <= hpsm_pkg::SUM_RESET;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
      // low partial product must survive while the finish step waits
      if (state_ff != S_FIN) begin
         prod_ff <= mul_p;
      end
      phi_ff  <= phi_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      if (load_out) begin
         rsp_status_ff <= stat_ff;
         case (stat_ff)
            hpsm_pkg::STATUS_STALLED: begin
               rsp_speed_ff <= '0;
               rsp_omega_ff <= '0;
            end
            hpsm_pkg::STATUS_SATURATED: begin
               rsp_speed_ff <= hpsm_pkg::SPEED_MAX;
               rsp_omega_ff <= hpsm_pkg::OMEGA_MAX;
            end
            default: begin
               // quotient < 2^46 since num < 2^48 and den >= 6: no clamp
               rsp_speed_ff <= quo_ff;
               rsp_omega_ff <= omega_sat;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_speed_rps = rsp_speed_ff;
   assign rsp_omega     = rsp_omega_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // stale count tracks the per-slot stale bits
   a_stale_count: assert property (@(posedge clock) disable iff (reset)
      stale_cnt_ff == hpsm_pkg::STALE_W'($countones(stale_ff)))
      else $error("stale count out of step with stale bits");

   // divider remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not reduced");

   // a stalled response carries zero speed
   a_stalled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == hpsm_pkg::STATUS_STALLED) |->
      (rsp_speed_rps == '0 && rsp_omega == '0))
      else $error("stalled response with nonzero speed");

   // a new response is loaded only when the previous one is gone or leaving
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_omega) && $stable(rsp_speed_rps))
      else $error("pending response overwritten");

endmodule

`default_nettype wire
